// File: rtl/mrwf_pkg.sv
// Shared types, step codes and the CRC-16/MODBUS byte update for the framer.
`timescale 1ns / 1ps
package mrwf_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    // Position of the byte being sent within one queued command
    localparam logic [3:0] STEP_ADDR    = 4'd0;
    localparam logic [3:0] STEP_FUNC    = 4'd1;
    localparam logic [3:0] STEP_REG_HI  = 4'd2;
    localparam logic [3:0] STEP_REG_LO  = 4'd3;
    localparam logic [3:0] STEP_CNT_HI  = 4'd4;
    localparam logic [3:0] STEP_CNT_LO  = 4'd5;
    localparam logic [3:0] STEP_LEN     = 4'd6;
    localparam logic [3:0] STEP_PAYLOAD = 4'd7;
    localparam logic [3:0] STEP_CRC_LO  = 4'd8;
    localparam logic [3:0] STEP_CRC_HI  = 4'd9;

    // One classified item handed from the front to the back
    typedef struct packed {
        logic        first;        // send the seven header bytes first
        logic        has_payload;  // send payload_byte
        logic        ends;         // append the CRC and close the frame
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [15:0] start_register;
        logic [15:0] register_count;
        logic [7:0]  byte_count;
        logic [7:0]  payload_byte;
    } cmd_t;

    // Status of the decoupling queue as seen by the back part
    typedef struct packed {
        logic empty;
        cmd_t head;
    } queue_out_t;

    // Fold one byte into the CRC, LSB first, reflected polynomial
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CrcPoly;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// File: rtl/modbus_rtu_write_framer.sv
// Top level of the Modbus RTU write request framer.
//
// Input channel s_*: one item per payload byte. The first item of a frame
// carries the header (address, function, start register, register count,
// byte count) and the first payload byte; later items carry one payload
// byte each. A zero byte count makes a frame of header and CRC only.
// Output channel m_*: one item per frame byte in transmit order, with
// tlast on the CRC high byte. CRC-16/MODBUS is sent low byte first.
// The first byte of an item passes through the command queue, the command
// register and the output register. The byte serialiser sends one byte per
// cycle while the receiver takes it, so payload items stream at one per cycle;
// a header item sends eight to ten bytes and a closing item three. A
// four-entry command queue lets the input side run ahead meanwhile.
// Reset empties the queue and the output register; s_tready is high
// afterwards. When the receiver stalls, the output register holds its byte,
// the queue fills and s_tready falls once it is full.
`timescale 1ns / 1ps
module modbus_rtu_write_framer
    import mrwf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slave_address[7:0], function_code[15:8], start_register[31:16],
    // register_count[47:32], byte_count[55:48], payload_byte[63:56]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_byte[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    logic       push, pop, q_full;
    cmd_t       push_cmd;
    queue_out_t q_out;

    mrwf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    mrwf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .q_out    (q_out)
    );

    mrwf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_out    (q_out),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/mrwf_front.sv
// Front part: accepts items, tracks the frame and classifies each item.
`timescale 1ns / 1ps
module mrwf_front
    import mrwf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        q_full,
    output logic        push,
    output cmd_t        push_cmd
);

    logic       in_frame_reg, in_frame_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] len;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;
    assign len      = s_tdata[55:48];

    // Classify the item against the current frame position
    always_comb begin
        push_cmd.slave_address  = s_tdata[7:0];
        push_cmd.function_code  = s_tdata[15:8];
        push_cmd.start_register = s_tdata[31:16];
        push_cmd.register_count = s_tdata[47:32];
        push_cmd.byte_count     = len;
        push_cmd.payload_byte   = s_tdata[63:56];
        if (!in_frame_reg) begin
            push_cmd.first       = 1'b1;
            push_cmd.has_payload = (len != 8'd0);
            push_cmd.ends        = (len <= 8'd1);
            in_frame_next        = (len > 8'd1);
            left_next            = len - 8'd1;
        end else begin
            push_cmd.first       = 1'b0;
            push_cmd.has_payload = 1'b1;
            push_cmd.ends        = (left_reg == 8'd1);
            in_frame_next        = (left_reg != 8'd1);
            left_next            = left_reg - 8'd1;
        end
    end

    // Advance the frame tracker on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            left_reg     <= 8'd0;
        end else if (push) begin
            in_frame_reg <= in_frame_next;
            left_reg     <= left_next;
        end
    end

endmodule

// File: rtl/mrwf_queue.sv
// Short command queue that decouples the front and back parts.
`timescale 1ns / 1ps
module mrwf_queue
    import mrwf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cmd_t       push_cmd,
    input  logic       pop,
    output logic       full,
    output queue_out_t q_out
);

    cmd_t                 mem [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg;
    logic [QueuePtrW-1:0] rd_ptr_reg;
    logic [QueueCntW-1:0] count_reg;

    assign full        = (count_reg == QueueCntW'(QueueDepth));
    assign q_out.empty = (count_reg == '0);
    assign q_out.head  = mem[rd_ptr_reg];

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/mrwf_back.sv
// Back part: serialises queued commands into frame bytes and appends the CRC.
`timescale 1ns / 1ps
module mrwf_back
    import mrwf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  queue_out_t q_out,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    cmd_t        cmd_reg;
    logic        act_reg;
    logic [3:0]  step_reg, step_next;
    logic [15:0] crc_reg, crc_base;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;
    logic [7:0]  byte_cur;
    logic        out_free, emit, cmd_done;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = act_reg && out_free;
    assign crc_base = (step_reg == STEP_ADDR) ? CrcInit : crc_reg;

    // Select the byte for this step and the step that follows it
    always_comb begin
        step_next = step_reg + 4'd1;
        cmd_done  = 1'b0;
        case (step_reg)
            STEP_ADDR:    byte_cur = cmd_reg.slave_address;
            STEP_FUNC:    byte_cur = cmd_reg.function_code;
            STEP_REG_HI:  byte_cur = cmd_reg.start_register[15:8];
            STEP_REG_LO:  byte_cur = cmd_reg.start_register[7:0];
            STEP_CNT_HI:  byte_cur = cmd_reg.register_count[15:8];
            STEP_CNT_LO:  byte_cur = cmd_reg.register_count[7:0];
            STEP_LEN: begin
                byte_cur = cmd_reg.byte_count;
                if (!cmd_reg.has_payload) begin
                    step_next = STEP_CRC_LO;
                end
            end
            STEP_PAYLOAD: begin
                byte_cur = cmd_reg.payload_byte;
                cmd_done = !cmd_reg.ends;
            end
            STEP_CRC_LO:  byte_cur = crc_reg[7:0];
            STEP_CRC_HI: begin
                byte_cur = crc_reg[15:8];
                cmd_done = 1'b1;
            end
            default: begin
                byte_cur = 8'h00;
                cmd_done = 1'b1;
            end
        endcase
    end

    assign pop = !q_out.empty && (!act_reg || (emit && cmd_done));

    // Load the next command or advance through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg  <= 1'b0;
            step_reg <= STEP_ADDR;
        end else if (pop) begin
            act_reg  <= 1'b1;
            step_reg <= q_out.head.first ? STEP_ADDR : STEP_PAYLOAD;
        end else if (emit && cmd_done) begin
            act_reg  <= 1'b0;
        end else if (emit) begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= q_out.head;
        end
    end

    // Fold every header and payload byte into the running CRC
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CrcInit;
        end else if (emit && (step_reg <= STEP_PAYLOAD)) begin
            crc_reg <= crc_update(crc_base, byte_cur);
        end
    end

    // Hold the byte in the output register until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= byte_cur;
            m_tlast_reg <= (step_reg == STEP_CRC_HI);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: rtl/mrwf_checker.sv
// Port-level checker for the framer and its bind to the top level.
`timescale 1ns / 1ps
module mrwf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    logic [8:0] since_last_reg;

    // Count bytes sent since the last end of frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            since_last_reg <= 9'd0;
        end else if (m_tvalid && m_tready) begin
            since_last_reg <= m_tlast ? 9'd0 : since_last_reg + 9'd1;
        end
    end

    a_reset_out_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    a_min_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |-> since_last_reg >= 9'd8)
        else $error("frame shorter than header and CRC");

endmodule

bind modbus_rtu_write_framer mrwf_checker u_mrwf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
